>>> hdl/cbmb_pkg.sv
`timescale 1ns / 1ps
package cbmb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_RADIUS   = 3;
  localparam int PIXEL_BITS   = 8;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int LINE_COUNT   = 3 * MAX_RADIUS + 1;

  localparam int DIM_BITS  = 11;
  localparam int RAD_BITS  = 2;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int LINE_BITS = $clog2(LINE_COUNT);
  localparam int ADDR_BITS = LINE_BITS + COL_BITS;
  localparam int RAM_DEPTH = LINE_COUNT * MAX_WIDTH;
  localparam int POS_BITS  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);

  localparam int TAP_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_BITS  = $clog2(TAP_MAX * ((1 << PIXEL_BITS) - 1) + 1);
  localparam int CNT_BITS  = $clog2(TAP_MAX + 1);
  localparam int REM_BITS  = CNT_BITS + 1;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(240);
  localparam logic [RAD_BITS-1:0] RADIUS_RESET = RAD_BITS'(2);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2
  } reg_index_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_TAPS  = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_taps;
    logic tap_step;
    logic div_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic taps_last;
    logic div_done;
  } status_t;

endpackage

>>> hdl/cbmb_ram.sv
`timescale 1ns / 1ps
module cbmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cbmb_ctrl.sv
`timescale 1ns / 1ps
module cbmb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  cbmb_pkg::status_t status,
  output cbmb_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid
);

  cbmb_pkg::state_t state, state_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state)
      cbmb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = cbmb_pkg::ST_CHECK;
        end
      end
      cbmb_pkg::ST_CHECK: begin
        if (status.emit) begin
          cmd.start_taps = 1'b1;
          state_next     = cbmb_pkg::ST_TAPS;
        end else begin
          state_next = cbmb_pkg::ST_IDLE;
        end
      end
      cbmb_pkg::ST_TAPS: begin
        cmd.tap_step = 1'b1;
        if (status.taps_last) begin
          state_next = cbmb_pkg::ST_FLUSH;
        end
      end
      cbmb_pkg::ST_FLUSH: begin
        state_next = cbmb_pkg::ST_DIV;
      end
      cbmb_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = cbmb_pkg::ST_OUT;
        end
      end
      cbmb_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next  = cbmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbmb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/cbmb_datapath.sv
`timescale 1ns / 1ps
module cbmb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cbmb_pkg::cmd_t                      cmd,
  output cbmb_pkg::status_t                   status,
  input  logic                                req_type,
  input  logic [cbmb_pkg::PIXEL_BITS-1:0]     pixel_value,
  output logic [cbmb_pkg::PIXEL_BITS-1:0]     blurred_value,
  output logic                                frame_last,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [cbmb_pkg::DIM_BITS-1:0]       cfg_wdata
);

  localparam int DB = cbmb_pkg::DIM_BITS;
  localparam int PB = cbmb_pkg::POS_BITS;
  localparam int LB = cbmb_pkg::LINE_BITS;
  localparam int CB = cbmb_pkg::COL_BITS;
  localparam int RB = cbmb_pkg::RAD_BITS;
  localparam int SB = cbmb_pkg::SUM_BITS;
  localparam int NB = cbmb_pkg::CNT_BITS;
  localparam int MB = cbmb_pkg::REM_BITS;
  localparam int TB = cbmb_pkg::STEP_BITS;
  localparam logic [LB-1:0] LAST_LINE = LB'(cbmb_pkg::LINE_COUNT - 1);
  localparam logic [DB-1:0] W_MAX = DB'(cbmb_pkg::MAX_WIDTH);
  localparam logic [DB-1:0] H_MAX = DB'(cbmb_pkg::HEIGHT_LIMIT);

  // Configuration registers.
  logic [DB-1:0] cfg_width, cfg_height;
  logic [RB-1:0] radius;

  // Input and output position counters.
  logic [DB-1:0] in_row, oi;
  logic [CB-1:0] in_col, oj;
  logic [LB-1:0] in_line, oi_line;
  logic [PB-1:0] recv, pos;

  // Window walk and divider.
  logic [DB-1:0] rr, r1_q;
  logic [LB-1:0] rr_line;
  logic [CB-1:0] cc, c0_q, c1_q;
  logic          rd_valid;
  logic [SB-1:0] sum;
  logic [NB-1:0] count;
  logic [MB-1:0] rem;
  logic [TB-1:0] div_cnt;
  logic [cbmb_pkg::PIXEL_BITS-1:0] rdata;

  logic [DB-1:0] w_eff, h_eff, oj_w, r_ext, r0, r1, c0, c1, row_back;
  logic [PB-1:0] total, need_raw, need;
  logic          write_en;
  logic [MB-1:0] rem_try;
  logic [LB-1:0] start_line;

  always_comb begin
    w_eff = (cfg_width == '0) ? DB'(1) : ((cfg_width > W_MAX) ? W_MAX : cfg_width);
    h_eff = (cfg_height == '0) ? DB'(1) : ((cfg_height > H_MAX) ? H_MAX : cfg_height);
    total = PB'(w_eff) * PB'(h_eff);
    r_ext = DB'(radius);
    need_raw = pos + PB'(r_ext) * PB'(w_eff) + PB'(radius) + PB'(1);
    need = (need_raw > total) ? total : need_raw;
    status.emit = (pos < total) && (recv >= need);

    oj_w = DB'(oj);
    r0 = (oi > r_ext) ? oi - r_ext : '0;
    r1 = (oi + r_ext < h_eff) ? oi + r_ext : h_eff - DB'(1);
    c0 = (oj_w > r_ext) ? oj_w - r_ext : '0;
    c1 = (oj_w + r_ext < w_eff) ? oj_w + r_ext : w_eff - DB'(1);
    row_back = oi - r0;
    if (oi_line < LB'(row_back)) begin
      start_line = oi_line + LB'(cbmb_pkg::LINE_COUNT) - LB'(row_back);
    end else begin
      start_line = oi_line - LB'(row_back);
    end

    status.taps_last = (rr == r1_q) && (cc == c1_q);
    status.div_done  = (div_cnt == TB'(SB - 1));
    write_en = cmd.accept && !req_type && (recv < total);
    rem_try  = {rem[MB-2:0], sum[SB-1]};
    blurred_value = sum[cbmb_pkg::PIXEL_BITS-1:0];
    frame_last = (pos == total - PB'(1));
  end

  cbmb_ram #(
    .WIDTH(cbmb_pkg::PIXEL_BITS),
    .DEPTH(cbmb_pkg::RAM_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (write_en),
    .waddr({in_line, in_col}),
    .wdata(pixel_value),
    .raddr({rr_line, cc}),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= cbmb_pkg::WIDTH_RESET;
      cfg_height <= cbmb_pkg::HEIGHT_RESET;
      radius     <= cbmb_pkg::RADIUS_RESET;
      in_row <= '0; in_col <= '0; in_line <= '0; recv <= '0;
      oi <= '0; oj <= '0; oi_line <= '0; pos <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.tap_step;
      if (cfg_we && (cfg_addr == cbmb_pkg::REG_FRAME_WIDTH ||
                     cfg_addr == cbmb_pkg::REG_FRAME_HEIGHT ||
                     cfg_addr == cbmb_pkg::REG_WINDOW_RADIUS)) begin
        unique case (cfg_addr)
          cbmb_pkg::REG_FRAME_WIDTH:   cfg_width  <= cfg_wdata;
          cbmb_pkg::REG_FRAME_HEIGHT:  cfg_height <= cfg_wdata;
          cbmb_pkg::REG_WINDOW_RADIUS: radius     <= cfg_wdata[RB-1:0];
          default: ;
        endcase
        in_row <= '0; in_col <= '0; in_line <= '0; recv <= '0;
        oi <= '0; oj <= '0; oi_line <= '0; pos <= '0;
      end else begin
        if (write_en) begin
          recv <= recv + PB'(1);
          if (DB'(in_col) + DB'(1) >= w_eff) begin
            in_col  <= '0;
            in_row  <= in_row + DB'(1);
            in_line <= (in_line == LAST_LINE) ? '0 : in_line + LB'(1);
          end else begin
            in_col <= in_col + CB'(1);
          end
        end
        if (cmd.advance) begin
          if (pos + PB'(1) >= total) begin
            in_row <= '0; in_col <= '0; in_line <= '0; recv <= '0;
            oi <= '0; oj <= '0; oi_line <= '0; pos <= '0;
          end else begin
            pos <= pos + PB'(1);
            if (oj_w + DB'(1) >= w_eff) begin
              oj      <= '0;
              oi      <= oi + DB'(1);
              oi_line <= (oi_line == LAST_LINE) ? '0 : oi_line + LB'(1);
            end else begin
              oj <= oj + CB'(1);
            end
          end
        end
      end
    end
  end

  // Window walk, accumulation and restoring division share the sum register:
  // after the division steps it holds the quotient.
  always_ff @(posedge clk) begin
    if (cmd.start_taps) begin
      rr      <= r0;
      r1_q    <= r1;
      rr_line <= start_line;
      cc      <= c0[CB-1:0];
      c0_q    <= c0[CB-1:0];
      c1_q    <= c1[CB-1:0];
      sum     <= '0;
      count   <= '0;
      rem     <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.tap_step) begin
        count <= count + NB'(1);
        if (cc == c1_q) begin
          cc      <= c0_q;
          rr      <= rr + DB'(1);
          rr_line <= (rr_line == LAST_LINE) ? '0 : rr_line + LB'(1);
        end else begin
          cc <= cc + CB'(1);
        end
      end
      if (rd_valid) begin
        sum <= sum + SB'(rdata);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + TB'(1);
        if (rem_try >= MB'(count)) begin
          rem <= rem_try - MB'(count);
          sum <= {sum[SB-2:0], 1'b1};
        end else begin
          rem <= rem_try;
          sum <= {sum[SB-2:0], 1'b0};
        end
      end
    end
  end

endmodule

>>> hdl/clipped_box_mean_blur.sv
`timescale 1ns / 1ps
// Edge-clipped box mean blur. Pixels of one plane arrive in raster order, one
// word each; the block returns, for each pixel, the truncated mean of the
// (2r+1) x (2r+1) window around it, counting only taps that fall inside the
// image. Results lag the input by r rows plus r pixels; once a frame is
// complete, send drain words (tuser high) to flush the remaining results, one
// per drain word, and the final result of the frame carries tlast. Drain
// words sent before the frame is complete produce nothing. Items are handled
// one at a time: a word with no result returns to idle after the check, and
// one with a result goes on to read its T (1 to 49) in-image window taps, one
// per cycle through the line store's single read port, then a flush state,
// the 14 restoring division steps on the 14-bit window sum, and the output
// state until the result is taken. Writing any configuration register
// restarts the frame; write only while the block is idle. The line store is
// ten lines of 1024 pixels and needs no clearing.
module clipped_box_mean_blur (
  input  logic                                clk,
  input  logic                                rst,
  // Input: tdata = pixel_value[7:0]; tuser = req_type (1 = drain word).
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                s_axis_tuser,
  // Output: tdata = blurred_value[7:0]; tlast = frame_last.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tlast,
  // Register write: 0 frame_width, 1 frame_height, 2 window_radius.
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [cbmb_pkg::DIM_BITS-1:0]       cfg_wdata
);

  cbmb_pkg::cmd_t    cmd;
  cbmb_pkg::status_t status;

  cbmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_ready(m_axis_tready),
    .status   (status),
    .cmd      (cmd),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid)
  );

  cbmb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (s_axis_tuser),
    .pixel_value  (s_axis_tdata),
    .blurred_value(m_axis_tdata),
    .frame_last   (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cbmb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input word: tdata = pixel_value[7:0]; tuser = req_type (1 = drain word).
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  // Output word: tdata = blurred_value[7:0]; tlast = frame_last.
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_addr = '0;
  logic [DIM_BITS-1:0] cfg_wdata = '0;

  clipped_box_mean_blur u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One predicted output word.
  typedef struct {
    logic [7:0] blurred;
    logic       last;
  } blur_word_t;

  // Predictor state: its own copy of the line store, counters and registers.
  logic [7:0]          pred_lines [RAM_DEPTH];
  int unsigned         pred_row, pred_col, pred_pos;
  logic [DIM_BITS-1:0] pred_width_reg, pred_height_reg;
  logic [RAD_BITS-1:0] pred_radius_reg;

  blur_word_t pending_blur[$];
  int  error_count = 0;
  int  words_sent = 0, words_seen = 0, frames_seen = 0;
  bit  calm_phase = 1'b0;     // no random idling near the end of the run
  bit  hold_request = 1'b0;   // asks the receiver for one long hold-off
  int  quiet_cycles = 0;
  int  flat_expect = -1;      // typed-in value for every word of a flat frame

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the result, if any, that one accepted input word causes.
  // Returns 1 and fills the word when a result is due.
  function automatic bit predict_blur(bit drain, logic [7:0] pixel,
                                      output blur_word_t res);
    int unsigned w, h, r, total, recv, need, oi, oj, r0, r1, c0, c1, sum, cnt;
    w = clamp_dim(pred_width_reg, MAX_WIDTH);
    h = clamp_dim(pred_height_reg, HEIGHT_LIMIT);
    r = pred_radius_reg;
    total = w * h;
    recv = pred_row * w + pred_col;
    res.blurred = '0;
    res.last = 1'b0;
    if (!drain && recv < total) begin
      pred_lines[(pred_row % LINE_COUNT) * MAX_WIDTH + pred_col] = pixel;
      pred_col++;
      if (pred_col >= w) begin
        pred_col = 0;
        pred_row++;
      end
      recv++;
    end
    if (pred_pos >= total) return 1'b0;
    need = pred_pos + r * w + r + 1;
    if (need > total) need = total;
    if (recv < need) return 1'b0;
    oi = pred_pos / w;
    oj = pred_pos % w;
    r0 = (oi > r) ? oi - r : 0;
    r1 = (oi + r < h) ? oi + r : h - 1;
    c0 = (oj > r) ? oj - r : 0;
    c1 = (oj + r < w) ? oj + r : w - 1;
    sum = 0;
    cnt = 0;
    for (int unsigned rr = r0; rr <= r1; rr++)
      for (int unsigned cc = c0; cc <= c1; cc++) begin
        sum += pred_lines[(rr % LINE_COUNT) * MAX_WIDTH + cc];
        cnt++;
      end
    res.blurred = 8'(sum / cnt);
    res.last = (pred_pos == total - 1);
    pred_pos++;
    if (pred_pos >= total) begin
      pred_row = 0;
      pred_col = 0;
      pred_pos = 0;
    end
    return 1'b1;
  endfunction

  // Offer one word and wait until the block takes it, then queue the
  // expected result. The sender idles in random bursts beforehand.
  task automatic send_word(bit drain, logic [7:0] pixel);
    blur_word_t res;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= drain;
    s_axis_tdata <= pixel;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (predict_blur(drain, pixel, res)) pending_blur.push_back(res);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the block settle, so a
  // register write only lands while the block is idle.
  task automatic wait_idle();
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [DIM_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:   pred_width_reg = value;
      REG_FRAME_HEIGHT:  pred_height_reg = value;
      REG_WINDOW_RADIUS: pred_radius_reg = value[RAD_BITS-1:0];
      default: ;
    endcase
    pred_row = 0;
    pred_col = 0;
    pred_pos = 0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, DIM_BITS'(w));
    write_reg(REG_FRAME_HEIGHT, DIM_BITS'(h));
    write_reg(REG_WINDOW_RADIUS, DIM_BITS'(r));
  endtask

  // Sends a whole frame of pixels followed by enough words to flush it.
  // The flush words are mostly drain words; some are pixels past the frame
  // end, which the block treats as drain words.
  // kind 0: random, 1: all 255, 2: all 0, 3: alternating extremes.
  task automatic send_frame(int unsigned kind);
    int unsigned w, h, total, r;
    logic [7:0] px;
    w = clamp_dim(pred_width_reg, MAX_WIDTH);
    h = clamp_dim(pred_height_reg, HEIGHT_LIMIT);
    r = pred_radius_reg;
    total = w * h;
    for (int unsigned i = 0; i < total; i++) begin
      case (kind)
        1: px = 8'hFF;
        2: px = 8'h00;
        3: px = i[0] ? 8'hFF : 8'h00;
        default: px = 8'($urandom_range(0, 255));
      endcase
      send_word(1'b0, px);
    end
    while (pred_pos != 0 || pred_row != 0 || pred_col != 0)
      send_word($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
  endtask

  // Directed table: one row per small frame, covering sizes and radii at
  // their extremes. Expected values are typed in for the flat frames only,
  // where the mean of a constant image is that constant.
  typedef struct {
    int unsigned w, h, r, kind;
    int          flat_value;   // -1: check against the predictor only
  } frame_row_t;

  frame_row_t directed_rows[] = '{
    '{1, 1, 0, 1, 255}, '{1, 1, 3, 2, 0}, '{4, 3, 1, 1, 255},
    '{3, 4, 3, 2, 0}, '{5, 5, 2, 3, -1}, '{7, 2, 3, 0, -1},
    '{1, 9, 2, 0, -1}, '{9, 1, 1, 0, -1}, '{8, 8, 3, 3, -1},
    '{6, 5, 0, 0, -1}
  };

  // Output side: random stalls, one long hold-off on request, and the check
  // of every word against the oldest expectation.
  always @(posedge clk) begin
    blur_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (m_axis_tlast) frames_seen++;
      if (flat_expect >= 0 && m_axis_tdata !== 8'(flat_expect)) begin
        $error("blurred_value: expected %0d, got %0d", flat_expect, m_axis_tdata);
        error_count++;
      end
      if (pending_blur.size() == 0) begin
        $error("unexpected output word: tdata %0d tlast %0b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_blur.pop_front();
        if (m_axis_tdata !== want.blurred) begin
          $error("blurred_value: expected %0d, got %0d", want.blurred, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with nothing accepted on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("** clipped_box_mean_blur: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned w, h;
    pred_width_reg = WIDTH_RESET;
    pred_height_reg = HEIGHT_RESET;
    pred_radius_reg = RADIUS_RESET;
    pred_row = 0;
    pred_col = 0;
    pred_pos = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight after reset the block holds 320 x 240, radius 2. Drain words
    // sent before a frame is complete must be ignored; a few pixels then
    // start that frame, which the first register write below aborts.
    send_word(1'b1, 8'hFF);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    stop_sending();

    foreach (directed_rows[i]) begin
      set_frame(directed_rows[i].w, directed_rows[i].h, directed_rows[i].r);
      // Flat frames: every output word must equal the typed-in value.
      flat_expect = directed_rows[i].flat_value;
      send_frame(directed_rows[i].kind);
      stop_sending();
      wait_idle();
      flat_expect = -1;
    end

    // Out-of-range sizes: zero reads as one, large values saturate.
    set_frame(0, 0, 1);
    send_word(1'b0, 8'h5A);
    send_word(1'b0, 8'hA5);   // the one-pixel frame is done, so this starts another
    stop_sending();
    set_frame(2047, 1, 0);    // width saturates at the full line length
    send_frame(0);
    stop_sending();
    set_frame(2, 2047, 0);    // too tall: leave it partially filled
    for (int i = 0; i < 8; i++) send_word(1'b0, 8'($urandom_range(0, 255)));
    stop_sending();

    // Pressure: the receiver holds off while the sender keeps offering.
    set_frame(4, 4, 1);
    hold_request = 1'b1;
    send_frame(0);
    stop_sending();

    // Random frames, mostly small, until about 1300 words have been sent.
    while (words_sent < 1300) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      set_frame(w, h, $urandom_range(0, 3));
      if (words_sent > 1100) calm_phase = 1'b1;
      // Occasionally a drain word too early, which must be ignored.
      if ($urandom_range(0, 3) == 0) send_word(1'b1, 8'($urandom_range(0, 255)));
      send_frame(0);
      // Occasionally extra words after the frame: they start a new frame
      // that the next register write aborts.
      if ($urandom_range(0, 3) == 0) send_word(1'b0, 8'($urandom_range(0, 255)));
      stop_sending();
    end

    wait_idle();
    $display("Sent %0d input words over many frame sizes and radii 0 to 3.", words_sent);
    $display("Checked %0d output words across %0d complete frames.", words_seen, frames_seen);
    if (error_count == 0)
      $display("** clipped_box_mean_blur: PASSED **");
    else
      $display("** clipped_box_mean_blur: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hdl/cbmb_pkg.sv
hdl/cbmb_ram.sv
hdl/cbmb_ctrl.sv
hdl/cbmb_datapath.sv
hdl/clipped_box_mean_blur.sv
test/testbench.sv
